// ===== sv/aioc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aioc_pkg
// shared types and constants for the arcade input and credit controller
// ----------------------------------------------------------------------------
package aioc_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_START = 2'd3
  } kind_t;

  // command bytes
  localparam logic [7:0] CMD_COINAGE    = 8'h01;
  localparam logic [7:0] CMD_CREDIT_ON  = 8'h02;
  localparam logic [7:0] CMD_REMAP_OFF  = 8'h03;
  localparam logic [7:0] CMD_REMAP_ON   = 8'h04;
  localparam logic [7:0] CMD_CREDIT_OFF = 8'h05;

  localparam logic [6:0] CREDIT_MAX   = 7'd99;
  localparam logic [7:0] LEFT_BIT     = 8'h08;
  localparam logic [7:0] RIGHT_BIT    = 8'h02;
  localparam logic [7:0] FIRE_BIT     = 8'h10;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;
  localparam logic [2:0] COINAGE_ARGS = 3'd4;
  localparam logic [1:0] COUNT_MAX    = 2'd3;

  // divide by ten for 0..99 via reciprocal: (x * 205) >> 11
  localparam logic [7:0] TEN_RECIP    = 8'd205;
  localparam int         TEN_SHIFT    = 11;

endpackage

// ===== sv/arcade_io_credit_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_io_credit_controller_core
// coin and start credit keeping, player-one control byte and bus protocol
// ----------------------------------------------------------------------------
// results: a read item gives its result in the output register in the cycle
//   after acceptance; other items give no result
// throughput: one item per cycle, held off only while a result waits and the
//   output side stalls (the output register is the only stage)
// reset: synchronous, active high; clears credits, modes, counters and edge
//   history, and sets the player-one byte to all released
module arcade_io_credit_controller_core
  import aioc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic       coin,
  input  logic       start_one,
  input  logic       start_two,
  input  logic       stick_left,
  input  logic       stick_right,
  input  logic       fire_button,
  input  logic [7:0] write_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_byte
);

  // controller state
  logic [2:0] args_left,        args_left_next;
  logic       credit_poll_on,   credit_poll_on_next;
  logic       remap_on,         remap_on_next;
  logic [1:0] transfer_count,   transfer_count_next;
  logic [6:0] credits,          credits_next;
  logic [7:0] player_one_byte,  player_one_byte_next;
  logic       coin_before,      coin_before_next;
  logic       start_one_before, start_one_before_next;
  logic       start_two_before, start_two_before_next;
  logic       fire_before,      fire_before_next;
  logic       fire_latched,     fire_latched_next;

  logic       in_accept;
  logic       read_accept;
  logic [1:0] count_adv;
  logic [6:0] cred_a, cred_b;
  logic [14:0] tens_prod;
  logic [3:0] tens;
  logic [6:0] ones_full;
  logic [7:0] bcd_byte;
  logic [7:0] read_value;
  logic [7:0] p1_sample;

  // the output register frees the input side whenever it is empty or draining
  assign in_ready    = !out_valid || out_ready;
  assign in_accept   = in_valid && in_ready;
  assign read_accept = in_accept && (kind_t'(kind) == KIND_READ);

  // saturating transfer counter step
  assign count_adv = (transfer_count < COUNT_MAX) ? transfer_count + 2'd1 : transfer_count;

  // credit count to bcd, tens by reciprocal multiply
  assign tens_prod = 15'(credits) * 15'(TEN_RECIP);
  assign tens      = tens_prod[TEN_SHIFT +: 4];
  assign ones_full = credits - 7'(tens) * 7'd10;
  assign bcd_byte  = {tens, ones_full[3:0]};

  // frame sample: coin edge first, then each start edge in turn
  always_comb begin
    cred_a = credits;
    if (coin && !coin_before && credits < CREDIT_MAX) cred_a = credits + 7'd1;
    cred_b = cred_a;
    if (start_one && !start_one_before && cred_a != 7'd0) cred_b = cred_a - 7'd1;
  end

  always_comb begin
    p1_sample = IDLE_BYTE;
    if (stick_left)  p1_sample = p1_sample & ~LEFT_BIT;
    if (stick_right) p1_sample = p1_sample & ~RIGHT_BIT;
    if (fire_latched || (fire_button && !fire_before)) p1_sample = p1_sample & ~FIRE_BIT;
  end

  // byte returned on a read
  always_comb begin
    read_value = IDLE_BYTE;
    if (credit_poll_on) begin
      if (transfer_count == 2'd0)      read_value = bcd_byte;
      else if (transfer_count == 2'd1) read_value = player_one_byte;
    end
  end

  // next state for one accepted item
  always_comb begin
    args_left_next        = args_left;
    credit_poll_on_next   = credit_poll_on;
    remap_on_next         = remap_on;
    transfer_count_next   = transfer_count;
    credits_next          = credits;
    player_one_byte_next  = player_one_byte;
    coin_before_next      = coin_before;
    start_one_before_next = start_one_before;
    start_two_before_next = start_two_before;
    fire_before_next      = fire_before;
    fire_latched_next     = fire_latched;
    if (in_accept) begin
      unique case (kind_t'(kind))
        KIND_FRAME: begin
          credits_next = cred_b;
          if (start_two && !start_two_before && cred_b != 7'd0) credits_next = cred_b - 7'd1;
          coin_before_next      = coin;
          start_one_before_next = start_one;
          start_two_before_next = start_two;
          fire_latched_next     = fire_latched || (fire_button && !fire_before);
          fire_before_next      = fire_button;
          player_one_byte_next  = p1_sample;
        end
        KIND_WRITE: begin
          transfer_count_next = count_adv;
          if (args_left != 3'd0) begin
            // coinage argument bytes are swallowed
            args_left_next = args_left - 3'd1;
          end else begin
            unique case (write_byte)
              CMD_COINAGE:    args_left_next      = COINAGE_ARGS;
              CMD_CREDIT_ON:  credit_poll_on_next = 1'b1;
              CMD_REMAP_OFF:  remap_on_next       = 1'b0;
              CMD_REMAP_ON:   remap_on_next       = 1'b1;
              CMD_CREDIT_OFF: credit_poll_on_next = 1'b0;
              default: ;
            endcase
          end
        end
        KIND_READ: begin
          transfer_count_next = count_adv;
          // reading the player-one byte retires the fire pulse
          if (credit_poll_on && transfer_count == 2'd1) fire_latched_next = 1'b0;
        end
        KIND_START: transfer_count_next = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      args_left        <= 3'd0;
      credit_poll_on   <= 1'b0;
      remap_on         <= 1'b0;
      transfer_count   <= 2'd0;
      credits          <= 7'd0;
      player_one_byte  <= IDLE_BYTE;
      coin_before      <= 1'b0;
      start_one_before <= 1'b0;
      start_two_before <= 1'b0;
      fire_before      <= 1'b0;
      fire_latched     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      args_left        <= args_left_next;
      credit_poll_on   <= credit_poll_on_next;
      remap_on         <= remap_on_next;
      transfer_count   <= transfer_count_next;
      credits          <= credits_next;
      player_one_byte  <= player_one_byte_next;
      coin_before      <= coin_before_next;
      start_one_before <= start_one_before_next;
      start_two_before <= start_two_before_next;
      fire_before      <= fire_before_next;
      fire_latched     <= fire_latched_next;
      if (read_accept)    out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register, payload needs no reset
  always_ff @(posedge clk) begin
    if (read_accept) read_byte <= read_value;
  end

  // credit count stays in range
  a_credit_range: assert property (@(posedge clk) disable iff (rst)
    credits <= CREDIT_MAX)
    else $error("credit count out of range");

  // transfer start clears the counter
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind == KIND_START |=> transfer_count == 2'd0)
    else $error("transfer counter not cleared");

  // remap command takes effect when no arguments are pending
  a_remap_on: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind == KIND_WRITE && args_left == 3'd0 && write_byte == CMD_REMAP_ON
    |=> remap_on)
    else $error("remap command lost");

  // every accepted read gives a result
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    read_accept |=> out_valid)
    else $error("read item gave no result");

  // an accepted read in credit mode at count zero returns the bcd credit
  a_read_bcd: assert property (@(posedge clk) disable iff (rst)
    read_accept && credit_poll_on && transfer_count == 2'd0
    |=> read_byte == $past(bcd_byte))
    else $error("credit read wrong");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the arcade input and credit controller core: a
// scoreboard tracks credits, button history, bus modes and the transfer
// counter, predicts every read byte and checks the output items in order
// ----------------------------------------------------------------------------
module testbench
  import aioc_pkg::*;
();

  // one bus item as offered on the input channel
  typedef struct packed {
    kind_t      kind;
    logic       coin;
    logic       start_one;
    logic       start_two;
    logic       stick_left;
    logic       stick_right;
    logic       fire_button;
    logic [7:0] write_byte;
  } bus_item_t;

  // tracks controller state and the read bytes still owed by the block
  class credit_scoreboard;
    logic [2:0] args_left;
    logic       poll_on;
    logic       remap;
    logic [1:0] xfer_count;
    logic [6:0] credits;
    logic [7:0] p1_byte;
    logic       coin_q, start_one_q, start_two_q, fire_q, fire_armed;
    logic [7:0] read_bytes_due[$];
    int         errors;

    function new();
      args_left   = '0;
      poll_on     = 1'b0;
      remap       = 1'b0;
      xfer_count  = '0;
      credits     = '0;
      p1_byte     = IDLE_BYTE;
      coin_q      = 1'b0;
      start_one_q = 1'b0;
      start_two_q = 1'b0;
      fire_q      = 1'b0;
      fire_armed  = 1'b0;
      errors      = 0;
    endfunction

    function void bump_count();
      if (xfer_count != COUNT_MAX) xfer_count = xfer_count + 2'd1;
    endfunction

    function void note_item(bus_item_t it);
      logic [7:0] p;
      logic [6:0] tens, ones;
      case (it.kind)
        KIND_FRAME: begin
          if (it.coin && !coin_q && credits < CREDIT_MAX) credits = credits + 7'd1;
          if (it.start_one && !start_one_q && credits != 0) credits = credits - 7'd1;
          if (it.start_two && !start_two_q && credits != 0) credits = credits - 7'd1;
          coin_q      = it.coin;
          start_one_q = it.start_one;
          start_two_q = it.start_two;
          p = IDLE_BYTE;
          if (it.stick_left) p = p & ~LEFT_BIT;
          if (it.stick_right) p = p & ~RIGHT_BIT;
          if (it.fire_button && !fire_q) fire_armed = 1'b1;
          fire_q = it.fire_button;
          if (fire_armed) p = p & ~FIRE_BIT;
          p1_byte = p;
        end
        KIND_WRITE: begin
          if (args_left != 0) begin
            args_left = args_left - 3'd1;
          end else begin
            case (it.write_byte)
              CMD_COINAGE:    args_left = COINAGE_ARGS;
              CMD_CREDIT_ON:  poll_on = 1'b1;
              CMD_REMAP_OFF:  remap = 1'b0;
              CMD_REMAP_ON:   remap = 1'b1;
              CMD_CREDIT_OFF: poll_on = 1'b0;
              default: ;
            endcase
          end
          bump_count();
        end
        KIND_READ: begin
          p = IDLE_BYTE;
          if (poll_on) begin
            if (xfer_count == 2'd0) begin
              tens = credits / 7'd10;
              ones = credits % 7'd10;
              p = {tens[3:0], ones[3:0]};
            end else if (xfer_count == 2'd1) begin
              p = p1_byte;
              fire_armed = 1'b0;
            end
          end
          bump_count();
          read_bytes_due.push_back(p);
        end
        default: xfer_count = '0;
      endcase
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        $error("read_byte: no read outstanding, got %h", got);
        errors++;
      end else begin
        want = read_bytes_due.pop_front();
        if (got !== want) begin
          $error("read_byte: expected %h, got %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int SQUEEZE_CYCLES = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = '0;
  logic       coin = 1'b0;
  logic       start_one = 1'b0;
  logic       start_two = 1'b0;
  logic       stick_left = 1'b0;
  logic       stick_right = 1'b0;
  logic       fire_button = 1'b0;
  logic [7:0] write_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_byte;

  credit_scoreboard sb = new();

  int send_idle_pct = 20;
  int rx_stall_pct = 55;
  int items_sent = 0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  int squeeze_left = 0;

  arcade_io_credit_controller_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .coin        (coin),
    .start_one   (start_one),
    .start_two   (start_two),
    .stick_left  (stick_left),
    .stick_right (stick_right),
    .fire_button (fire_button),
    .write_byte  (write_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // output side: check each accepted item, then pick the next ready level;
  // a long hold-off is counted here once the stimulus asks for it
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(read_byte);
    if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      out_ready    <= 1'b0;
    end else if (squeeze_left != 0) begin
      squeeze_left <= squeeze_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // fills the fields the block ignores for this kind with noise
  function automatic bus_item_t noisy_item(kind_t k);
    bus_item_t it;
    it             = bus_item_t'(16'($urandom));
    it.kind        = k;
    return it;
  endfunction

  function automatic bus_item_t frame_item(logic c, logic s1, logic s2, logic l,
                                           logic r, logic f);
    bus_item_t it;
    it             = noisy_item(KIND_FRAME);
    it.coin        = c;
    it.start_one   = s1;
    it.start_two   = s2;
    it.stick_left  = l;
    it.stick_right = r;
    it.fire_button = f;
    return it;
  endfunction

  function automatic bus_item_t write_item(logic [7:0] b);
    bus_item_t it;
    it            = noisy_item(KIND_WRITE);
    it.write_byte = b;
    return it;
  endfunction

  // offers one item and waits for the handshake; called just after an edge
  task automatic offer_item(bus_item_t it);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    coin        <= it.coin;
    start_one   <= it.start_one;
    start_two   <= it.start_two;
    stick_left  <= it.stick_left;
    stick_right <= it.stick_right;
    fire_button <= it.fire_button;
    write_byte  <= it.write_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // coin edges with the start buttons released, to push credits to the cap
  task automatic pump_coins(int n);
    repeat (n) begin
      offer_item(frame_item(1'b1, 1'b0, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom)));
      offer_item(frame_item(1'b0, 1'b0, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom)));
    end
  endtask

  task automatic send_command();
    int pick, nargs;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 30) b = CMD_CREDIT_ON;
    else if (pick < 40) b = CMD_CREDIT_OFF;
    else if (pick < 55) b = CMD_COINAGE;
    else if (pick < 65) b = CMD_REMAP_ON;
    else if (pick < 75) b = CMD_REMAP_OFF;
    else b = 8'($urandom_range(0, 255));
    offer_item(write_item(b));
    if (b == CMD_COINAGE) begin
      // mostly the full argument run, now and then a short or long one
      nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : COINAGE_ARGS;
      repeat (nargs) offer_item(write_item(8'($urandom_range(0, 255))));
    end
  endtask

  // random traffic made of short bus and cabinet sequences
  task automatic run_random(int goal);
    int pick, n;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // poll: optional credit mode on, transfer start, then reads
        if ($urandom_range(0, 4) == 0) offer_item(write_item(CMD_CREDIT_ON));
        offer_item(noisy_item(KIND_START));
        n = $urandom_range(1, 4);
        repeat (n) offer_item(noisy_item(KIND_READ));
      end else if (pick < 65) begin
        n = $urandom_range(1, 6);
        repeat (n)
          offer_item(frame_item(1'($urandom), $urandom_range(0, 99) < 20,
                                $urandom_range(0, 99) < 20, 1'($urandom),
                                1'($urandom), 1'($urandom)));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) offer_item(noisy_item(KIND_START));
        send_command();
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) offer_item(noisy_item(kind_t'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles lightly, receiver stalls often
    send_idle_pct = 20;
    rx_stall_pct  = 55;

    // read outside credit mode, then enter it and read zero credits
    offer_item(noisy_item(KIND_READ));
    offer_item(write_item(CMD_CREDIT_ON));
    offer_item(noisy_item(KIND_START));
    offer_item(noisy_item(KIND_READ));
    // coin edges, all controls held, fire pulse latched
    offer_item(frame_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    offer_item(frame_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    offer_item(frame_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    // both start edges in one frame each take a credit
    offer_item(frame_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    // start on empty credits takes nothing
    offer_item(frame_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_item(frame_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    // full transfer: credit, player one (retires fire), player two, past end
    offer_item(noisy_item(KIND_START));
    repeat (5) offer_item(noisy_item(KIND_READ));
    // coinage swallows command-looking arguments
    offer_item(write_item(CMD_COINAGE));
    offer_item(write_item(8'hFF));
    offer_item(write_item(CMD_CREDIT_OFF));
    offer_item(write_item(CMD_COINAGE));
    offer_item(write_item(8'h00));
    // unknown bytes, remap, credit mode off
    offer_item(write_item(8'h07));
    offer_item(write_item(8'hFF));
    offer_item(write_item(CMD_REMAP_ON));
    offer_item(write_item(CMD_REMAP_OFF));
    offer_item(write_item(CMD_CREDIT_OFF));
    offer_item(noisy_item(KIND_READ));

    // push credits past the cap, then read them back
    pump_coins(105);
    offer_item(write_item(CMD_CREDIT_ON));
    offer_item(noisy_item(KIND_START));
    offer_item(noisy_item(KIND_READ));
    run_random(600);

    // phase two: sender idles often, receiver stalls lightly
    send_idle_pct = 55;
    rx_stall_pct  = 20;
    run_random(1100);

    // phase three: no idling; first a long receiver hold-off under a
    // back-to-back burst so the output stage fills and input stalls
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    offer_item(write_item(CMD_CREDIT_ON));
    squeeze_req <= 1'b1;
    repeat (15) begin
      offer_item(noisy_item(KIND_START));
      offer_item(noisy_item(KIND_READ));
      offer_item(noisy_item(KIND_READ));
    end
    run_random(1550);

    in_valid <= 1'b0;
    while (sb.read_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
